### src/paphq_pkg.sv
// ----------------------------------------------------------------------------
// paphq_pkg: shared types and constants
// Action and status codes, default sizes, memory request struct.
// ----------------------------------------------------------------------------
`default_nettype none
package paphq_pkg;
  localparam int ASSETS_DEF      = 16;
  localparam int SLICE_DEPTH_DEF = 256;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_LAST = 2'd1;
  localparam logic [1:0] ACT_PEAK = 2'd2;
  localparam logic [1:0] ACT_WMAX = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ASSET = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic        wr;
    logic [15:0] day;
    logic [31:0] price;
    logic [31:0] run;
  } row_t;
endpackage
`default_nettype wire

### src/paphq_row_mem.sv
// ----------------------------------------------------------------------------
// paphq_row_mem: row storage
// One-port synchronous memory of (day, price, running max) rows.
// ----------------------------------------------------------------------------
`default_nettype none
module paphq_row_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic               clk,
  input  wire logic [AW-1:0]      addr,
  input  wire paphq_pkg::row_t    wdata,
  output logic [15:0]             rday,
  output logic [31:0]             rprice,
  output logic [31:0]             rrun
);
  logic [79:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wdata.wr) begin
      mem[addr] <= {wdata.day, wdata.price, wdata.run};
    end
    {rday, rprice, rrun} <= mem[addr];
  end
endmodule
`default_nettype wire

### src/per_asset_price_history_query.sv
// ----------------------------------------------------------------------------
// per_asset_price_history_query: per-asset sorted price history with queries
// Loads append rows; queries binary search an asset slice by day.
// ----------------------------------------------------------------------------
// One transaction at a time on the single row memory port. A load reads
// the previous row (S_FETCH), then writes the new row with its running
// max (S_LPREV). Last/peak does a read then a compare per probe, up to
// ceil(log2(n+1)) probes, then reads the result row unless none matches;
// window max runs both searches, then reads each row in the window. Busy
// stays high through the result strobe, next accept the cycle after.
// Reset clears slice counts and load order state; row memory is not cleared.
// The receiver cannot stall: result shows for one cycle with done high.
`default_nettype none
module per_asset_price_history_query #(
  parameter int ASSETS      = paphq_pkg::ASSETS_DEF,
  parameter int SLICE_DEPTH = paphq_pkg::SLICE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  asset,
  input  wire logic [15:0] day,
  input  wire logic [15:0] day_to,
  input  wire logic [31:0] price,
  output logic             done,
  output logic [1:0]       status,
  output logic             found,
  output logic [31:0]      value
);
  localparam int SW = $clog2(SLICE_DEPTH);       // row index width
  localparam int CW = $clog2(SLICE_DEPTH + 1);   // count width
  localparam int XW = (ASSETS > 1) ? $clog2(ASSETS) : 1;
  localparam int AW = XW + SW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;  // search read issued
  localparam logic [2:0] S_CMP   = 3'd2;  // search compare
  localparam logic [2:0] S_FETCH = 3'd3;  // result row (or load's previous row) read issued
  localparam logic [2:0] S_TAKE  = 3'd4;  // result row data
  localparam logic [2:0] S_SCAN  = 3'd5;  // window row data
  localparam logic [2:0] S_LPREV = 3'd6;  // load: previous row data

  logic [2:0]  state;
  logic [1:0]  act;
  logic [XW-1:0] ast;
  logic [15:0] qday, qto;
  logic [31:0] qprice;
  logic [CW-1:0] cnt [ASSETS];
  logic [15:0] last_day;
  logic        any_loaded;
  logic [CW-1:0] lo, hi, mid, lo_res;
  logic [CW-1:0] mid_c;  // probe row, addressed while in S_PROBE
  logic        pass2;   // window: second search running
  logic [31:0] acc;
  logic        acc_v;
  logic [CW-1:0] n;

  logic [AW-1:0]   maddr;
  paphq_pkg::row_t wrow;
  logic [15:0] rday;
  logic [31:0] rprice, rrun;

  assign busy  = (state != S_IDLE) || done;
  assign n     = cnt[ast];
  assign mid_c = lo + ((hi - lo) >> 1);

  paphq_row_mem #(.DEPTH(2 ** AW), .AW(AW)) u_mem (
    .clk(clk), .addr(maddr), .wdata(wrow),
    .rday(rday), .rprice(rprice), .rrun(rrun)
  );

  // Search compare: go right on rday <= key for last/peak and the window end, on rday < key for the window start.
  logic        go_right;
  logic [15:0] key;
  assign key      = pass2 ? qto : qday;
  assign go_right = (act == paphq_pkg::ACT_WMAX && !pass2) ? (rday < key) : (rday <= key);

  logic [CW-1:0] lo_n, hi_n;
  assign lo_n = go_right ? mid + CW'(1) : lo;
  assign hi_n = go_right ? hi : mid;

  always_comb begin
    maddr = {ast, mid[SW-1:0]};
    wrow  = '{wr: 1'b0, day: qday, price: qprice, run: qprice};
    if (state == S_PROBE) begin
      // issue the probe read so the row is ready in S_CMP
      maddr = {ast, mid_c[SW-1:0]};
    end
    if (state == S_LPREV) begin
      maddr = {ast, n[SW-1:0]};
      wrow.wr = 1'b1;
      if (n != '0 && rrun > qprice) begin
        wrow.run = rrun;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      last_day   <= '0;
      any_loaded <= 1'b0;
      for (int i = 0; i < ASSETS; i++) cnt[i] <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            act    <= action;
            ast    <= XW'(asset);
            qday   <= day;
            qto    <= day_to;
            qprice <= price;
            pass2  <= 1'b0;
            acc    <= '0;
            acc_v  <= 1'b0;
            status <= paphq_pkg::ST_OK;
            found  <= 1'b0;
            value  <= '0;
            lo     <= '0;
            if ({1'b0, asset} >= 9'(ASSETS)) begin
              status <= paphq_pkg::ST_ASSET;
              done   <= 1'b1;
            end else if (action == paphq_pkg::ACT_LOAD) begin
              if (any_loaded && day < last_day) begin
                status <= paphq_pkg::ST_ORDER;
                done   <= 1'b1;
              end else if (cnt[XW'(asset)] >= CW'(SLICE_DEPTH)) begin
                status <= paphq_pkg::ST_FULL;
                done   <= 1'b1;
              end else begin
                mid   <= cnt[XW'(asset)] - CW'(1);
                state <= S_FETCH;
              end
            end else begin
              hi    <= cnt[XW'(asset)];
              state <= S_PROBE;
            end
          end
        end
        S_FETCH: begin
          // read of row mid issued this cycle
          state <= (act == paphq_pkg::ACT_LOAD) ? S_LPREV : S_TAKE;
        end
        S_LPREV: begin
          cnt[ast]   <= n + CW'(1);
          last_day   <= qday;
          any_loaded <= 1'b1;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= S_CMP;
          end else if (act == paphq_pkg::ACT_WMAX && !pass2) begin
            lo_res <= lo;
            pass2  <= 1'b1;
            lo     <= '0;
            hi     <= n;
          end else if (act == paphq_pkg::ACT_WMAX) begin
            hi <= lo;
            if (lo_res < lo) begin
              mid   <= lo_res;
              state <= S_SCAN;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else if (lo != '0) begin
            mid   <= lo - CW'(1);
            state <= S_FETCH;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CMP: begin
          lo    <= lo_n;
          hi    <= hi_n;
          state <= S_PROBE;
        end
        S_TAKE: begin
          found <= 1'b1;
          value <= (act == paphq_pkg::ACT_LAST) ? rprice : rrun;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN: begin
          // a read phase then a data phase per row, toggled via acc_v
          if (!acc_v) begin
            acc_v <= 1'b1;
          end else begin
            acc_v <= 1'b0;
            if (rprice > acc || mid == lo_res) acc <= rprice;
            if (mid + CW'(1) < hi) begin
              mid <= mid + CW'(1);
            end else begin
              found <= 1'b1;
              value <= (rprice > acc || mid == lo_res) ? rprice : acc;
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("busy low with result");
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == paphq_pkg::ST_OK)) else $error("found with error");
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (value == '0)) else $error("value not zero");
`endif
endmodule
`default_nettype wire

### dv/per_asset_price_history_query_tb.sv
// ----------------------------------------------------------------------------
// per_asset_price_history_query_tb: self-checking bench for the price history
// Drives loads and day queries through the start/busy handshake, predicts
// every result from a local copy of the per-asset slices and checks each
// done strobe in order against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: owns the history copy, predicts and checks results
class price_history_scoreboard;
  localparam int NA = paphq_pkg::ASSETS_DEF;
  localparam int ND = paphq_pkg::SLICE_DEPTH_DEF;

  typedef struct {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value;
  } outcome_t;

  int unsigned   rows [NA];
  logic [15:0]   row_day [NA][ND];
  logic [31:0]   row_price [NA][ND];
  logic [31:0]   row_peak [NA][ND];
  logic [15:0]   last_day;
  bit            seen_load;
  outcome_t      pending [$];
  int unsigned   mismatches;

  function void clear();
    foreach (rows[a]) rows[a] = 0;
    last_day   = '0;
    seen_load  = 0;
    pending.delete();
    mismatches = 0;
  endfunction

  // First index whose day exceeds d (above) or is at least d (not above)
  function int unsigned locate(int unsigned a, logic [15:0] d, bit above);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = rows[a];
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (above ? (row_day[a][mid] <= d) : (row_day[a][mid] < d)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Note one accepted transaction and queue its outcome
  function void note_request(logic [1:0] act, logic [7:0] asset, logic [15:0] day,
                             logic [15:0] day_to, logic [31:0] price);
    outcome_t    o;
    int unsigned n, k, lo, hi;
    logic [31:0] m;
    o = '{paphq_pkg::ST_OK, 1'b0, 32'd0};
    if (asset >= NA) begin
      o.status = paphq_pkg::ST_ASSET;
    end else begin
      n = rows[asset];
      case (act)
        paphq_pkg::ACT_LOAD: begin
          if (seen_load && day < last_day) o.status = paphq_pkg::ST_ORDER;
          else if (n >= ND) o.status = paphq_pkg::ST_FULL;
          else begin
            m = price;
            if (n > 0 && row_peak[asset][n-1] > m) m = row_peak[asset][n-1];
            row_day[asset][n]   = day;
            row_price[asset][n] = price;
            row_peak[asset][n]  = m;
            rows[asset]         = n + 1;
            last_day            = day;
            seen_load           = 1;
          end
        end
        paphq_pkg::ACT_LAST, paphq_pkg::ACT_PEAK: begin
          k = locate(asset, day, 1);
          if (k > 0) begin
            o.found = 1;
            o.value = (act == paphq_pkg::ACT_LAST) ? row_price[asset][k-1]
                                                   : row_peak[asset][k-1];
          end
        end
        default: begin
          lo = locate(asset, day, 0);
          hi = locate(asset, day_to, 1);
          if (lo < hi) begin
            m = row_price[asset][lo];
            for (int unsigned i = lo + 1; i < hi; i++)
              if (row_price[asset][i] > m) m = row_price[asset][i];
            o.found = 1;
            o.value = m;
          end
        end
      endcase
    end
    pending.push_back(o);
  endfunction

  function void check_result(logic [1:0] status, logic found, logic [31:0] value);
    outcome_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: st=%0d f=%0d v=%0h",
                                     status, found, value);
      return;
    end
    e = pending.pop_front();
    if (status !== e.status || found !== e.found || value !== e.value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp st=%0d f=%0d v=%0h, got st=%0d f=%0d v=%0h",
                 e.status, e.found, e.value, status, found, value);
    end
  endfunction
endclass

module per_asset_price_history_query_tb;
  localparam int NUM_ASSETS = paphq_pkg::ASSETS_DEF;
  localparam int DEPTH      = paphq_pkg::SLICE_DEPTH_DEF;
  // idle-cycle watchdog: limit on cycles with neither an accept nor a result,
  // far above the longest window scan plus a sender idle gap
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [7:0]  asset;
  logic [15:0] day;
  logic [15:0] day_to;
  logic [31:0] price;
  logic        done;
  logic [1:0]  status;
  logic        found;
  logic [31:0] value;

  price_history_scoreboard history;
  int unsigned idle_cycles;
  bit          bursts_on;
  logic [15:0] day_cursor;   // day for the next well-formed load

  per_asset_price_history_query u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .action (action),
    .asset  (asset),
    .day    (day),
    .day_to (day_to),
    .price  (price),
    .done   (done),
    .status (status),
    .found  (found),
    .value  (value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: a transaction is accepted at start && !busy; results on done
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy)
        history.note_request(action, asset, day, day_to, price);
      if (done)
        history.check_result(status, found, value);
      idle_cycles <= (start && !busy) || done ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Issue one transaction, holding start until accepted
  task automatic issue(logic [1:0] a, logic [7:0] s, logic [15:0] d,
                       logic [15:0] dt, logic [31:0] p);
    action <= a;
    asset  <= s;
    day    <= d;
    day_to <= dt;
    price  <= p;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    // occasional idle burst between transactions
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_price();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_asset();
    // mostly valid assets; sometimes out of range
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(NUM_ASSETS, 255))
                                       : 8'($urandom_range(0, NUM_ASSETS - 1));
  endfunction

  task automatic random_item();
    logic [15:0] d, d2;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    d  = day_cursor - 16'($urandom_range(0, 300));
    d2 = d + 16'($urandom_range(0, 200));
    if (pick < 40) begin
      // well-formed load, days advance slowly; now and then out of order
      if ($urandom_range(0, 15) == 0) begin
        issue(paphq_pkg::ACT_LOAD, pick_asset(), 16'($urandom_range(0, day_cursor)),
              16'($urandom), pick_price());
      end else begin
        if (day_cursor < 16'hFF00) day_cursor += 16'($urandom_range(0, 3));
        issue(paphq_pkg::ACT_LOAD, pick_asset(), day_cursor, 16'($urandom),
              pick_price());
      end
    end else if (pick < 60) begin
      issue(paphq_pkg::ACT_LAST, pick_asset(), d, 16'($urandom), $urandom);
    end else if (pick < 80) begin
      issue(paphq_pkg::ACT_PEAK, pick_asset(), d, 16'($urandom), $urandom);
    end else if (pick < 95) begin
      issue(paphq_pkg::ACT_WMAX, pick_asset(), d, d2, $urandom);
    end else begin
      // full-range noise, including inverted windows
      issue(2'($urandom), pick_asset(), 16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  initial begin
    history    = new();
    history.clear();
    bursts_on  = 1'b1;
    day_cursor = 16'd12;
    rst    = 1'b1;
    start  = 1'b0;
    action = paphq_pkg::ACT_LOAD;
    asset  = '0;
    day    = '0;
    day_to = '0;
    price  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty slices, bad assets, edge values, order and window cases
    issue(paphq_pkg::ACT_LAST, 8'd0, 16'hFFFF, 16'd0, 32'd0);         // empty slice
    issue(paphq_pkg::ACT_WMAX, 8'd1, 16'd0, 16'hFFFF, 32'd0);
    issue(paphq_pkg::ACT_LOAD, 8'hFF, 16'd5, 16'd0, 32'd7);           // bad asset
    issue(paphq_pkg::ACT_PEAK, 8'(NUM_ASSETS), 16'd5, 16'd0, 32'd7);
    issue(paphq_pkg::ACT_LOAD, 8'd0, 16'd10, 16'hFFFF, 32'hFFFF_FFFF);
    issue(paphq_pkg::ACT_LOAD, 8'd0, 16'd10, 16'd0, 32'd0);           // equal day
    issue(paphq_pkg::ACT_LOAD, 8'd1, 16'd9, 16'd0, 32'd5);            // out of order
    issue(paphq_pkg::ACT_LOAD, 8'(NUM_ASSETS - 1), 16'd12, 16'd0, 32'd300);
    issue(paphq_pkg::ACT_LAST, 8'd0, 16'd9, 16'd0, 32'd0);            // before first
    issue(paphq_pkg::ACT_LAST, 8'd0, 16'd10, 16'd0, 32'd0);
    issue(paphq_pkg::ACT_PEAK, 8'd0, 16'd11, 16'd0, 32'd0);
    issue(paphq_pkg::ACT_WMAX, 8'd0, 16'd10, 16'd10, 32'd0);
    issue(paphq_pkg::ACT_WMAX, 8'd0, 16'd11, 16'd10, 32'd0);          // inverted
    issue(paphq_pkg::ACT_WMAX, 8'(NUM_ASSETS - 1), 16'd0, 16'hFFFF, 32'd0);
    issue(paphq_pkg::ACT_LAST, 8'(NUM_ASSETS - 1), 16'hFFFF, 16'd0, 32'd0);

    // Fill asset 2 to capacity, then probe the slice-full path
    for (int i = 0; i < DEPTH; i++) begin
      if (day_cursor < 16'hFF00) day_cursor += 16'(i % 2);
      issue(paphq_pkg::ACT_LOAD, 8'd2, day_cursor, 16'($urandom), $urandom);
    end
    issue(paphq_pkg::ACT_LOAD, 8'd2, day_cursor, 16'd0, 32'd1);       // slice full
    issue(paphq_pkg::ACT_WMAX, 8'd2, 16'd0, 16'hFFFF, 32'd0);         // longest scan
    issue(paphq_pkg::ACT_PEAK, 8'd2, 16'hFFFF, 16'd0, 32'd0);

    for (int i = 0; i < 800; i++) random_item();

    // Late part: top day range and no idle bursts
    bursts_on = 1'b0;
    day_cursor = 16'hFF00;
    for (int i = 0; i < 200; i++) random_item();
    issue(paphq_pkg::ACT_LOAD, 8'd3, 16'hFFFF, 16'd0, 32'd42);
    issue(paphq_pkg::ACT_LAST, 8'd3, 16'hFFFF, 16'hFFFF, 32'd0);
    start <= 1'b0;

    // drain pending results, then allow for trailing latency
    while (history.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (history.mismatches == 0 && history.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire
